// ----- sv/record_bubble_sort_by_key_core_assert.svh -----
// Assertion macros for the record sorter core
`ifndef RECORD_BUBBLE_SORT_BY_KEY_CORE_ASSERT_SVH
`define RECORD_BUBBLE_SORT_BY_KEY_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RBSK_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define RBSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rbsk_pkg.sv -----
// Package: constants, record type, codes and helpers of the record sorter
`timescale 1ns / 1ps

package rbsk_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int TYPE_CHARS  = 8;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int ID_W    = 6;
  localparam int PRICE_W = 24;
  localparam int CAP_W   = 16;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
  localparam int CHARS_W = 64;
  localparam int LEN_W   = 4;
  localparam int KEY_W   = 64;
  localparam int SKEY_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SORT_KEY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'b1;

  typedef enum logic [SKEY_W-1:0] {
    KEY_BIZ  = 3'd0,
    KEY_ECO  = 3'd1,
    KEY_CAP  = 3'd2,
    KEY_DATE = 3'd3,
    KEY_TYPE = 3'd4
  } sort_key_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ORD,
    ST_REC,
    ST_CMP,
    ST_END,
    ST_E_ORD,
    ST_E_REC,
    ST_E_OUT
  } st_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] biz;
    logic [PRICE_W-1:0] eco;
    logic [CAP_W-1:0]   cap;
    logic [DATE_W-1:0]  date;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
  } rec_t;

  // length saturated to TYPE_CHARS and cut at the first NUL
  function automatic logic [LEN_W-1:0] eff_len(input logic [CHARS_W-1:0] chars,
                                               input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] res;
    n   = (len > LEN_W'(TYPE_CHARS)) ? LEN_W'(TYPE_CHARS) : len;
    res = n;
    for (int i = TYPE_CHARS - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < n) && (chars[(CHARS_W-1-8*i) -: 8] == 8'h00)) begin
        res = LEN_W'(i);
      end
    end
    return res;
  endfunction

  // ones over the leading len characters
  function automatic logic [CHARS_W-1:0] type_mask(input logic [LEN_W-1:0] len);
    logic [CHARS_W-1:0] m;
    m = '0;
    for (int i = 0; i < TYPE_CHARS; i++) begin
      if (LEN_W'(i) < len) begin
        m[(CHARS_W-1-8*i) -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- sv/rbsk_if.sv -----
// Stream interfaces: record input channel and sorted id output channel
`timescale 1ns / 1ps

interface rbsk_in_if;
  logic                         valid;
  logic                         ready;
  logic [rbsk_pkg::ID_W-1:0]    record_id;
  logic [rbsk_pkg::PRICE_W-1:0] price_business;
  logic [rbsk_pkg::PRICE_W-1:0] price_economy;
  logic [rbsk_pkg::CAP_W-1:0]   capacity;
  logic [rbsk_pkg::YEAR_W-1:0]  year;
  logic [rbsk_pkg::MONTH_W-1:0] month;
  logic [rbsk_pkg::DAY_W-1:0]   day;
  logic [rbsk_pkg::CHARS_W-1:0] type_chars;
  logic [rbsk_pkg::LEN_W-1:0]   type_length;
  logic                         last_record;

  modport source (output valid, record_id, price_business, price_economy, capacity,
                  year, month, day, type_chars, type_length, last_record,
                  input ready);
  modport sink   (input valid, record_id, price_business, price_economy, capacity,
                  year, month, day, type_chars, type_length, last_record,
                  output ready);
endinterface

interface rbsk_out_if;
  logic                      valid;
  logic                      ready;
  logic [rbsk_pkg::ID_W-1:0] sorted_id;
  logic                      last_out;
  logic                      overflow;

  modport source (output valid, sorted_id, last_out, overflow, input ready);
  modport sink   (input valid, sorted_id, last_out, overflow, output ready);
endinterface

// ----- sv/rbsk_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module rbsk_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rbsk_cmp.sv -----
// Shared key comparator: true when record a is strictly greater on the chosen key
`timescale 1ns / 1ps

module rbsk_cmp (
  input  logic [rbsk_pkg::SKEY_W-1:0] sort_key_i,
  input  rbsk_pkg::rec_t              a_i,
  input  rbsk_pkg::rec_t              b_i,
  output logic                        gt_o
);

  logic [rbsk_pkg::KEY_W-1:0] op_a;
  logic [rbsk_pkg::KEY_W-1:0] op_b;
  logic [rbsk_pkg::LEN_W-1:0] min_len;
  logic [rbsk_pkg::CHARS_W-1:0] mask;

  // a shorter string compares equal to its extension: mask to the common prefix
  assign min_len = (a_i.len < b_i.len) ? a_i.len : b_i.len;
  assign mask    = rbsk_pkg::type_mask(min_len);

  always_comb begin
    case (sort_key_i)
      rbsk_pkg::KEY_ECO: begin
        op_a = rbsk_pkg::KEY_W'(a_i.eco);
        op_b = rbsk_pkg::KEY_W'(b_i.eco);
      end
      rbsk_pkg::KEY_CAP: begin
        op_a = rbsk_pkg::KEY_W'(a_i.cap);
        op_b = rbsk_pkg::KEY_W'(b_i.cap);
      end
      rbsk_pkg::KEY_DATE: begin
        op_a = rbsk_pkg::KEY_W'(a_i.date);
        op_b = rbsk_pkg::KEY_W'(b_i.date);
      end
      rbsk_pkg::KEY_TYPE: begin
        op_a = rbsk_pkg::KEY_W'(a_i.chars & mask);
        op_b = rbsk_pkg::KEY_W'(b_i.chars & mask);
      end
      default: begin
        op_a = rbsk_pkg::KEY_W'(a_i.biz);
        op_b = rbsk_pkg::KEY_W'(b_i.biz);
      end
    endcase
  end

  assign gt_o = op_a > op_b;

endmodule

// ----- sv/record_bubble_sort_by_key_core.sv -----
// Record sorter top level: load, bubble sort on a shared comparator, emit ids
//
//   channel   dir   beat carries
//   in_if     in    one record: id, key fields, last_record
//   out_if    out   one sorted id with last_out and overflow
//   cfg       in    write of sort_key or descending
//
// Load: one record per cycle. Sort: n-1 passes through one comparator fed by
// a record RAM and an order RAM; each position of a pass runs an order read,
// a record read and a compare. Emit: an order read, a record read and an
// output step per id, under output back-pressure. in_if.ready is low from
// the last record of a set until its final id has been loaded for output.
// No clearing pass after reset; the RAMs are only read where written.
`timescale 1ns / 1ps

`include "record_bubble_sort_by_key_core_assert.svh"

module record_bubble_sort_by_key_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rbsk_in_if.sink                         in_if,
  rbsk_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [rbsk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbsk_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IW = rbsk_pkg::IDX_W;
  localparam int CW = rbsk_pkg::CNT_W;

  rbsk_pkg::st_e state_q, state_d;

  logic [rbsk_pkg::SKEY_W-1:0] sort_key_q;
  logic                        descending_q;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [IW-1:0] last_q, last_d;
  logic          ord_init_q, ord_init_d;
  logic          out_valid_q, out_valid_d;

  rbsk_pkg::rec_t held_q, held_d;
  logic [IW-1:0]  held_slot_q, held_slot_d;
  logic [IW-1:0]  slot_q, slot_d;
  logic [rbsk_pkg::ID_W-1:0] out_id_q, out_id_d;
  logic           out_last_q, out_last_d;
  logic           out_ovf_q, out_ovf_d;

  rbsk_pkg::rec_t in_rec;
  rbsk_pkg::rec_t rec_rdata;
  logic           rec_we;
  logic [IW-1:0]  rec_raddr;
  logic           ord_we;
  logic [IW-1:0]  ord_waddr, ord_wdata, ord_raddr, ord_rdata;

  logic          gt;
  logic          in_acc;
  logic          full;
  logic [CW-1:0] n_new;
  logic [IW-1:0] n_m1;
  logic [IW-1:0] e_addr;
  logic          out_free;

  assign in_rec.id    = in_if.record_id;
  assign in_rec.biz   = in_if.price_business;
  assign in_rec.eco   = in_if.price_economy;
  assign in_rec.cap   = in_if.capacity;
  assign in_rec.date  = {in_if.year, in_if.month, in_if.day};
  assign in_rec.chars = in_if.type_chars;
  assign in_rec.len   = rbsk_pkg::eff_len(in_if.type_chars, in_if.type_length);

  assign in_if.ready = (state_q == rbsk_pkg::ST_LOAD);
  assign in_acc      = in_if.valid && in_if.ready;
  assign full        = (count_q == CW'(rbsk_pkg::MAX_RECORDS));
  assign n_new       = full ? count_q : count_q + CW'(1);
  assign rec_we      = in_acc && !full;
  assign n_m1        = IW'(count_q - CW'(1));
  assign e_addr      = descending_q ? (n_m1 - pos_q) : pos_q;
  assign out_free    = !out_valid_q || out_if.ready;

  assign out_if.valid     = out_valid_q;
  assign out_if.sorted_id = out_id_q;
  assign out_if.last_out  = out_last_q;
  assign out_if.overflow  = out_ovf_q;

  rbsk_ram #(
    .DATA_W ($bits(rbsk_pkg::rec_t)),
    .DEPTH  (rbsk_pkg::MAX_RECORDS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (in_rec),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  rbsk_ram #(
    .DATA_W (IW),
    .DEPTH  (rbsk_pkg::MAX_RECORDS)
  ) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  rbsk_cmp u_cmp (
    .sort_key_i (sort_key_q),
    .a_i        (held_q),
    .b_i        (rec_rdata),
    .gt_o       (gt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_key_q   <= '0;
      descending_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rbsk_pkg::CFG_SORT_KEY:   sort_key_q   <= cfg_wdata_i;
        rbsk_pkg::CFG_DESCENDING: descending_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbsk_pkg::ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      last_q      <= '0;
      ord_init_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      ord_init_q  <= ord_init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q      <= held_d;
    held_slot_q <= held_slot_d;
    slot_q      <= slot_d;
    out_id_q    <= out_id_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    last_d      = last_q;
    ord_init_d  = ord_init_q;
    out_valid_d = out_valid_q && !out_if.ready;
    held_d      = held_q;
    held_slot_d = held_slot_q;
    slot_d      = slot_q;
    out_id_d    = out_id_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    rec_raddr   = slot_q;
    ord_raddr   = pos_q;
    ord_we      = 1'b0;
    ord_waddr   = pos_q;
    ord_wdata   = held_slot_q;

    case (state_q)
      rbsk_pkg::ST_LOAD: begin
        if (in_acc) begin
          count_d = n_new;
          if (full) begin
            ovf_d = 1'b1;
          end
          if (in_if.last_record) begin
            pos_d      = '0;
            ord_init_d = 1'b0;
            last_d     = IW'(n_new - CW'(1));
            state_d    = (n_new == CW'(1)) ? rbsk_pkg::ST_E_ORD : rbsk_pkg::ST_ORD;
          end
        end
      end
      rbsk_pkg::ST_ORD: begin
        ord_raddr = pos_q;
        state_d   = rbsk_pkg::ST_REC;
      end
      rbsk_pkg::ST_REC: begin
        // first pass runs on the identity order
        slot_d    = ord_init_q ? ord_rdata : pos_q;
        rec_raddr = slot_d;
        state_d   = rbsk_pkg::ST_CMP;
      end
      rbsk_pkg::ST_CMP: begin
        if (pos_q == '0) begin
          held_d      = rec_rdata;
          held_slot_d = slot_q;
          pos_d       = pos_q + IW'(1);
          state_d     = rbsk_pkg::ST_ORD;
        end else begin
          ord_we    = 1'b1;
          ord_waddr = pos_q - IW'(1);
          if (gt) begin
            ord_wdata = slot_q;
          end else begin
            ord_wdata   = held_slot_q;
            held_d      = rec_rdata;
            held_slot_d = slot_q;
          end
          if (pos_q == last_q) begin
            state_d = rbsk_pkg::ST_END;
          end else begin
            pos_d   = pos_q + IW'(1);
            state_d = rbsk_pkg::ST_ORD;
          end
        end
      end
      rbsk_pkg::ST_END: begin
        ord_we     = 1'b1;
        ord_waddr  = last_q;
        ord_wdata  = held_slot_q;
        ord_init_d = 1'b1;
        pos_d      = '0;
        if (last_q == IW'(1)) begin
          state_d = rbsk_pkg::ST_E_ORD;
        end else begin
          last_d  = last_q - IW'(1);
          state_d = rbsk_pkg::ST_ORD;
        end
      end
      rbsk_pkg::ST_E_ORD: begin
        ord_raddr = e_addr;
        state_d   = rbsk_pkg::ST_E_REC;
      end
      rbsk_pkg::ST_E_REC: begin
        slot_d    = ord_init_q ? ord_rdata : e_addr;
        rec_raddr = slot_d;
        state_d   = rbsk_pkg::ST_E_OUT;
      end
      rbsk_pkg::ST_E_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = rec_rdata.id;
          out_last_d  = (pos_q == n_m1);
          out_ovf_d   = ovf_q;
          if (pos_q == n_m1) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = rbsk_pkg::ST_LOAD;
          end else begin
            pos_d   = pos_q + IW'(1);
            state_d = rbsk_pkg::ST_E_ORD;
          end
        end
      end
      default: begin
        state_d = rbsk_pkg::ST_LOAD;
      end
    endcase
  end

  `RBSK_ASSERT_IMPLY(a_count_cap, 1'b1, count_q <= CW'(rbsk_pkg::MAX_RECORDS), "record count beyond capacity")
  `RBSK_ASSERT_IMPLY(a_cmp_in_pass, state_q == rbsk_pkg::ST_CMP, pos_q <= last_q, "compare past pass end")
  `RBSK_ASSERT_IMPLY(a_end_nonzero, state_q == rbsk_pkg::ST_END, last_q != '0, "pass end with empty range")
  `RBSK_ASSERT_NEXT(a_last_leaves_load, in_acc && in_if.last_record, state_q != rbsk_pkg::ST_LOAD, "set end did not start sort")

endmodule

// ----- verif/tb_record_bubble_sort_by_key_core.sv -----
// Testbench of the record sorter core: directed and random record sets, checked beat by beat
`timescale 1ns / 1ps

module tb_record_bubble_sort_by_key_core;
  import rbsk_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_SHOWN     = 10;
  localparam int SETTLE_CYCLES = 16;
  // sort_key codes past the defined keys fall back to business price
  localparam logic [SKEY_W-1:0] KEY_SPARE_LO = 3'd5;
  localparam logic [SKEY_W-1:0] KEY_SPARE_HI = 3'd7;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] biz;
    logic [PRICE_W-1:0] eco;
    logic [CAP_W-1:0]   cap;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
    logic               last;
  } record_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            last;
    logic            ovf;
  } sorted_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rbsk_in_if  in_if ();
  rbsk_out_if out_if ();

  record_bubble_sort_by_key_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // sorter state as the block should hold it
  record_t           set_recs[MAX_RECORDS];
  logic [LEN_W-1:0]  set_len[MAX_RECORDS];
  int                set_count = 0;
  bit                set_ovf = 1'b0;
  logic [SKEY_W-1:0] cur_key = KEY_BIZ;
  bit                cur_desc = 1'b0;
  sorted_beat_t      sorted_q[$];

  int          failures = 0;
  int          cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_left = 0;
  sorted_beat_t want_beat;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // length clipped to TYPE_CHARS and cut at the first NUL
  function automatic logic [LEN_W-1:0] usable_len(input logic [CHARS_W-1:0] chars,
                                                  input logic [LEN_W-1:0] len);
    int n;
    n = (len > TYPE_CHARS) ? TYPE_CHARS : int'(len);
    for (int i = 0; i < n; i++) begin
      if (chars[CHARS_W-1-8*i -: 8] == 8'h00) return LEN_W'(i);
    end
    return LEN_W'(n);
  endfunction

  function automatic bit ranks_above(input int a, input int b);
    int n;
    logic [7:0] ca, cb;
    case (cur_key)
      KEY_ECO:  return set_recs[a].eco > set_recs[b].eco;
      KEY_CAP:  return set_recs[a].cap > set_recs[b].cap;
      KEY_DATE: return {set_recs[a].year, set_recs[a].month, set_recs[a].day} >
                       {set_recs[b].year, set_recs[b].month, set_recs[b].day};
      KEY_TYPE: begin
        n = int'((set_len[a] < set_len[b]) ? set_len[a] : set_len[b]);
        for (int i = 0; i < n; i++) begin
          ca = set_recs[a].chars[CHARS_W-1-8*i -: 8];
          cb = set_recs[b].chars[CHARS_W-1-8*i -: 8];
          if (ca != cb) return ca > cb;
        end
        return 1'b0;
      end
      default:  return set_recs[a].biz > set_recs[b].biz;
    endcase
  endfunction

  function automatic void predict_sorted_ids(input record_t r);
    int order[MAX_RECORDS];
    int tmp;
    int slot;
    sorted_beat_t beat;
    if (set_count < MAX_RECORDS) begin
      set_recs[set_count] = r;
      set_len[set_count]  = usable_len(r.chars, r.len);
      set_count++;
    end else begin
      set_ovf = 1'b1;
    end
    if (!r.last) return;
    for (int i = 0; i < set_count; i++) order[i] = i;
    for (int i = 0; i + 1 < set_count; i++) begin
      for (int j = 0; j + 1 < set_count - i; j++) begin
        if (ranks_above(order[j], order[j+1])) begin
          tmp        = order[j];
          order[j]   = order[j+1];
          order[j+1] = tmp;
        end
      end
    end
    for (int k = 0; k < set_count; k++) begin
      slot      = cur_desc ? order[set_count-1-k] : order[k];
      beat.id   = set_recs[slot].id;
      beat.last = (k == set_count - 1);
      beat.ovf  = set_ovf;
      sorted_q.push_back(beat);
    end
    set_count = 0;
    set_ovf   = 1'b0;
  endfunction

  // output side: random stall bursts with ready held low
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      stall_left   = $urandom_range(2, 0);
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (sorted_q.size() == 0) begin
        if (failures < MAX_SHOWN)
          $display("unexpected beat: id %0d last %b ovf %b",
                   out_if.sorted_id, out_if.last_out, out_if.overflow);
        failures++;
      end else begin
        want_beat = sorted_q.pop_front();
        if (out_if.sorted_id !== want_beat.id || out_if.last_out !== want_beat.last ||
            out_if.overflow !== want_beat.ovf) begin
          if (failures < MAX_SHOWN)
            $display("beat mismatch: expected id %0d last %b ovf %b, got id %0d last %b ovf %b",
                     want_beat.id, want_beat.last, want_beat.ovf,
                     out_if.sorted_id, out_if.last_out, out_if.overflow);
          failures++;
        end
      end
    end
  end

  task automatic send_record(input record_t r);
    @(negedge clk_i);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_if.record_id      = r.id;
    in_if.price_business = r.biz;
    in_if.price_economy  = r.eco;
    in_if.capacity       = r.cap;
    in_if.year           = r.year;
    in_if.month          = r.month;
    in_if.day            = r.day;
    in_if.type_chars     = r.chars;
    in_if.type_length    = r.len;
    in_if.last_record    = r.last;
    in_if.valid          = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_sorted_ids(r);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SORT_KEY) cur_key = data;
    else cur_desc = data[0];
  endtask

  task automatic set_order(input logic [SKEY_W-1:0] key, input bit desc);
    write_cfg(CFG_SORT_KEY, key);
    write_cfg(CFG_DESCENDING, CFG_DATA_W'(desc));
  endtask

  function automatic record_t blank_record(input logic [ID_W-1:0] id);
    record_t r;
    r       = '{default: '0};
    r.id    = id;
    return r;
  endfunction

  // narrow draws keep keys in a tiny range so ties and shared prefixes are common
  function automatic record_t rand_record(input bit narrow);
    record_t r;
    r.id = ID_W'($urandom);
    if (narrow) begin
      r.biz   = PRICE_W'($urandom_range(3, 0));
      r.eco   = PRICE_W'($urandom_range(3, 0));
      r.cap   = CAP_W'($urandom_range(3, 0));
      r.year  = YEAR_W'($urandom_range(2001, 2000));
      r.month = MONTH_W'($urandom_range(2, 1));
      r.day   = DAY_W'($urandom_range(2, 1));
      for (int i = 0; i < TYPE_CHARS; i++)
        r.chars[CHARS_W-1-8*i -: 8] = ($urandom_range(7, 0) == 0) ? 8'h00 :
                                      8'(8'h41 + $urandom_range(2, 0));
    end else begin
      r.biz   = PRICE_W'($urandom);
      r.eco   = PRICE_W'($urandom);
      r.cap   = CAP_W'($urandom);
      r.year  = YEAR_W'($urandom);
      r.month = MONTH_W'($urandom);
      r.day   = DAY_W'($urandom);
      r.chars = {$urandom, $urandom};
    end
    r.len  = ($urandom_range(3, 0) == 0) ? LEN_W'($urandom_range(15, 0)) :
                                           LEN_W'($urandom_range(8, 0));
    r.last = 1'b0;
    return r;
  endfunction

  task automatic send_set(input int n);
    record_t r;
    bit narrow;
    narrow = 1'($urandom_range(1, 0));
    for (int k = 0; k < n; k++) begin
      r      = rand_record(narrow ^ ($urandom_range(7, 0) == 0));
      r.last = (k == n - 1);
      send_record(r);
    end
  endtask

  // reset settings: business price, ascending
  task automatic test_extremes();
    record_t r;
    r       = blank_record(6'd63);
    r.biz   = '1;
    r.eco   = '1;
    r.cap   = '1;
    r.year  = '1;
    r.month = '1;
    r.day   = '1;
    r.chars = '1;
    r.len   = '1;
    r.last  = 1'b1;
    send_record(r);
    r      = blank_record(6'd0);
    r.last = 1'b1;
    send_record(r);
    r     = blank_record(6'd5);
    r.biz = '1;
    send_record(r);
    send_record(blank_record(6'd0));
    r     = blank_record(6'd63);
    r.biz = 24'h800000;
    send_record(r);
    r      = blank_record(6'd7);
    r.last = 1'b1;
    send_record(r);
  endtask

  task automatic test_date_order();
    record_t r;
    set_order(KEY_DATE, 1'b0);
    r = blank_record(6'd1);
    {r.year, r.month, r.day} = {12'd2000, 4'd12, 5'd31};
    send_record(r);
    r = blank_record(6'd2);
    {r.year, r.month, r.day} = {12'd2001, 4'd1, 5'd1};
    send_record(r);
    r = blank_record(6'd3);
    {r.year, r.month, r.day} = {12'd2000, 4'd12, 5'd30};
    send_record(r);
    r = blank_record(6'd4);
    {r.year, r.month, r.day} = {12'd2000, 4'd11, 5'd31};
    r.last = 1'b1;
    send_record(r);
  endtask

  // prefixes, NUL cut, oversized length and the empty string
  task automatic test_type_prefix();
    record_t r;
    set_order(KEY_TYPE, 1'b1);
    r       = blank_record(6'd10);
    r.chars = 64'h4142_4300_0000_0000;
    r.len   = 4'd3;
    send_record(r);
    r       = blank_record(6'd11);
    r.chars = 64'h4142_5A5A_5A5A_5A5A;
    r.len   = 4'd2;
    send_record(r);
    r       = blank_record(6'd12);
    r.chars = 64'h4142_4400_FFFF_FFFF;
    r.len   = 4'd8;
    send_record(r);
    r       = blank_record(6'd13);
    r.chars = 64'h4200_0000_0000_0000 | 64'h0000_7A7A_7A7A_7A7A;
    r.len   = 4'd15;
    send_record(r);
    r       = blank_record(6'd14);
    r.chars = 64'h3030_3030_3030_3030;
    r.last  = 1'b1;
    send_record(r);
  endtask

  task automatic test_spare_key();
    record_t r;
    set_order(KEY_SPARE_HI, 1'b0);
    r     = blank_record(6'd20);
    r.biz = 24'd900;
    r.eco = 24'd1;
    send_record(r);
    r      = blank_record(6'd21);
    r.biz  = 24'd100;
    r.eco  = 24'd9;
    r.last = 1'b1;
    send_record(r);
  endtask

  task automatic test_descending_ties();
    record_t r;
    set_order(KEY_CAP, 1'b1);
    r     = blank_record(6'd1);
    r.cap = 16'd5;
    send_record(r);
    r     = blank_record(6'd2);
    r.cap = 16'd5;
    send_record(r);
    r      = blank_record(6'd3);
    r.cap  = 16'd1;
    r.last = 1'b1;
    send_record(r);
  endtask

  task automatic test_random_sets();
    logic [SKEY_W-1:0] sweep[6];
    logic [SKEY_W-1:0] key;
    sweep = '{KEY_BIZ, KEY_ECO, KEY_CAP, KEY_DATE, KEY_TYPE, KEY_SPARE_HI};
    for (int p = 0; p < 12; p++) begin
      key      = (p < 6) ? sweep[p] : SKEY_W'($urandom_range(KEY_SPARE_HI, KEY_BIZ));
      set_order(key, (p < 6) ? p[0] : 1'($urandom_range(1, 0)));
      idle_pct = (p % 3 == 2) ? 0 : 20;
      repeat (3) send_set($urandom_range(8, 1));
    end
    set_order(KEY_SPARE_LO, 1'b1);
    send_set($urandom_range(20, 9));
  endtask

  task automatic test_full_and_overflow();
    idle_pct = 15;
    set_order(SKEY_W'($urandom_range(KEY_TYPE, KEY_BIZ)), 1'($urandom_range(1, 0)));
    send_set(MAX_RECORDS);
    drain_results();
    send_set(MAX_RECORDS + 3);
  endtask

  task automatic test_streaming();
    set_order(SKEY_W'($urandom_range(KEY_SPARE_HI, KEY_BIZ)), 1'($urandom_range(1, 0)));
    idle_pct = 0;
    repeat (10) send_set($urandom_range(10, 1));
  endtask

  initial begin
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_SORT_KEY;
    cfg_wdata_i           = '0;
    in_if.valid           = 1'b0;
    in_if.record_id       = '0;
    in_if.price_business  = '0;
    in_if.price_economy   = '0;
    in_if.capacity        = '0;
    in_if.year            = '0;
    in_if.month           = '0;
    in_if.day             = '0;
    in_if.type_chars      = '0;
    in_if.type_length     = '0;
    in_if.last_record     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 20;
    test_extremes();
    test_date_order();
    test_type_prefix();
    test_spare_key();
    test_descending_ties();
    test_random_sets();
    test_full_and_overflow();
    test_streaming();
    drain_results();

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/rbsk_pkg.sv
sv/rbsk_if.sv
sv/rbsk_ram.sv
sv/rbsk_cmp.sv
sv/record_bubble_sort_by_key_core.sv
verif/tb_record_bubble_sort_by_key_core.sv
